// ----- src/moving_rms_meter_defines.svh -----
// assertion macros for the moving rms meter
// used by moving_rms_meter.sv, needs clk_i and rst_ni in the including module
`ifndef MOVING_RMS_METER_DEFINES_SVH
`define MOVING_RMS_METER_DEFINES_SVH

// same-cycle implication
`define MRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mrm_pkg.sv -----
// package of the moving rms meter: widths, constants, register map, states
// no dependencies
package mrm_pkg;

  localparam int WINDOW_DEF = 10;
  localparam int SAMPLE_W   = 8;
  localparam int FS_W       = 13;
  localparam int Q_W        = 16;
  localparam int MV_W       = 13;
  localparam int PROD_W     = Q_W + FS_W;
  localparam int RAD_W      = 2 * Q_W;
  localparam int SREM_W     = Q_W + 2;
  localparam int STEP_W     = 4;
  localparam int ADDR_W     = 3;

  localparam logic [FS_W-1:0] FS_RESET = 13'd2980;
  localparam logic [Q_W-1:0]  Q8_FULL  = 16'd65280;

  // divide by 65280 as a drop of 8 bits, then multiply by the reciprocal of 255
  localparam int                 SCL_DROP = 8;
  localparam int                 RECIP_W  = 24;
  localparam int                 RECIP_SH = 31;
  localparam logic [RECIP_W-1:0] MV_RECIP = 24'h808081;

  localparam logic [0:0] REG_FULL_SCALE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DSTART,
    ST_DIV1,
    ST_SQRT,
    ST_MUL,
    ST_DIV2,
    ST_OUT
  } mrm_state_e;

endpackage

// ----- src/moving_rms_meter.sv -----
// moving rms meter: ring of samples in a memory, running sum of squares,
// restoring divider for the mean square and bit-serial square root; needs mrm_pkg
// and moving_rms_meter_defines.svh
//
// channel   dir  fields (low bit up)
// s_axis    in   tdata: sample[7:0]
// m_axis    out  tdata: rms_q8[15:0], rms_mv[28:16], zero[31:29]; tuser: window_full
// apb       in   register 0 at byte address 0: full_scale_mv[12:0]
//
// an item goes from request to the next ready through a ring update, a divider load,
// 16 mean-square divide steps, 16 root steps, a multiply, millivolt scaling by
// reciprocal, an output load (held while the last result is untaken), back to idle
// the divider and the root unit each resolve one result bit per cycle
// a finished result waits in the output register while the next sample is taken
// reset needs no clearing pass: slots not yet written read as zero by fill count
`include "moving_rms_meter_defines.svh"

module moving_rms_meter #(
  parameter int WINDOW = mrm_pkg::WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mrm_pkg::SAMPLE_W-1:0] s_axis_tdata,  // sample
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // rms_q8, rms_mv, zero pad
  output logic                        m_axis_tuser,  // window_full
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mrm_pkg::*;

  localparam int SUM_W   = $clog2(WINDOW * 65025 + 1);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DV_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int SCL_W   = DV_W - SCL_DROP;
  localparam int SCL_P_W = SCL_W + RECIP_W;

  mrm_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] win_mem [WINDOW];
  logic [SAMPLE_W-1:0] rdata_q;
  logic                mem_re, mem_we;

  logic [SAMPLE_W-1:0] smp_q, smp_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [FS_W-1:0]     fs_q, fs_d;

  logic [DV_W-1:0]     rem_q, rem_d;
  logic [DV_W-1:0]     dsh_q, dsh_d;
  logic [Q_W-1:0]      quo_q, quo_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [RAD_W-1:0]    rad_q, rad_d;
  logic [SREM_W-1:0]   srem_q, srem_d;
  logic [Q_W-1:0]      root_q, root_d;
  logic [Q_W-1:0]      rms_q, rms_d;
  logic [MV_W-1:0]     mv_q, mv_d;

  logic                ovalid_q, ovalid_d;
  logic [Q_W-1:0]      orms_q, orms_d;
  logic [MV_W-1:0]     omv_q, omv_d;
  logic                ofull_q, ofull_d;

  logic                full;
  logic [SAMPLE_W-1:0] old_smp;
  logic [2*SAMPLE_W-1:0] old_sq, new_sq;
  logic                div_ge;
  logic [Q_W-1:0]      quo_next;
  logic [SREM_W+1:0]   srem_t, srem_trial;
  logic                sq_ge;
  logic [Q_W-1:0]      root_next;
  logic [PROD_W-1:0]   prod;
  logic [SCL_P_W-1:0]  scl_prod;
  logic                cfg_we;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_FULL_SCALE);
  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_FULL_SCALE) begin
      prdata[FS_W-1:0] = fs_q;
    end
  end
  assign fs_d = cfg_we ? pwdata[FS_W-1:0] : fs_q;

  // window memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[pos_q] <= smp_q;
    end
    if (mem_re) begin
      rdata_q <= win_mem[pos_q];
    end
  end

  assign full      = (cnt_q == CNT_W'(WINDOW));
  assign old_smp   = full ? rdata_q : '0;
  assign old_sq    = old_smp * old_smp;
  assign new_sq    = smp_q * smp_q;

  assign div_ge    = (rem_q >= dsh_q);
  assign quo_next  = {quo_q[Q_W-2:0], div_ge};

  assign srem_t     = {srem_q, rad_q[RAD_W-1 -: 2]};
  assign srem_trial = {2'b00, root_q, 2'b01};
  assign sq_ge      = (srem_t >= srem_trial);
  assign root_next  = {root_q[Q_W-2:0], sq_ge};

  assign prod = PROD_W'(rms_q) * PROD_W'(fs_q);

  // product over 256, times the reciprocal of 255
  assign scl_prod = SCL_P_W'(rem_q[DV_W-1:SCL_DROP]) * SCL_P_W'(MV_RECIP);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(32 - Q_W - MV_W){1'b0}}, omv_q, orms_q};
  assign m_axis_tuser  = ofull_q;

  always_comb begin
    state_d  = state_q;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    smp_d    = smp_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    step_d   = step_q;
    rad_d    = rad_q;
    srem_d   = srem_q;
    root_d   = root_q;
    rms_d    = rms_q;
    mv_d     = mv_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    orms_d   = orms_q;
    omv_d    = omv_q;
    ofull_d  = ofull_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          smp_d   = s_axis_tdata;
          mem_re  = 1'b1;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        sum_d  = sum_q - SUM_W'(old_sq) + SUM_W'(new_sq);
        mem_we = 1'b1;
        pos_d  = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
        if (!full) begin
          cnt_d = cnt_q + 1'b1;
        end
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        rem_d   = DV_W'(sum_q);
        dsh_d   = DV_W'(cnt_q) << (Q_W - 1);
        quo_d   = '0;
        step_d  = STEP_W'(Q_W - 1);
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_ge) begin
          rem_d = rem_q - dsh_q;
        end
        dsh_d  = dsh_q >> 1;
        quo_d  = quo_next;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          rad_d   = {quo_next, {Q_W{1'b0}}};
          srem_d  = '0;
          root_d  = '0;
          step_d  = STEP_W'(Q_W - 1);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_d = sq_ge ? SREM_W'(srem_t - srem_trial) : SREM_W'(srem_t);
        root_d = root_next;
        rad_d  = rad_q << 2;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          rms_d   = root_next;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        rem_d   = DV_W'(prod);
        state_d = ST_DIV2;
      end
      ST_DIV2: begin
        mv_d    = scl_prod[RECIP_SH +: MV_W];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          orms_d   = rms_q;
          omv_d    = mv_q;
          ofull_d  = full;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sum_q    <= '0;
      cnt_q    <= '0;
      pos_q    <= '0;
      fs_q     <= FS_RESET;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      fs_q     <= fs_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q  <= smp_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    rms_q  <= rms_d;
    mv_q   <= mv_d;
    orms_q <= orms_d;
    omv_q  <= omv_d;
    ofull_q <= ofull_d;
  end

  `MRM_ASSERT_NEXT(a_accept_updates, s_axis_tvalid && s_axis_tready, state_q == ST_UPD, "request accepted but ring update skipped")
  `MRM_ASSERT_NOW(a_cnt_sat, 1'b1, cnt_q <= CNT_W'(WINDOW), "sample count beyond window")
  `MRM_ASSERT_NOW(a_div_bound, state_q == ST_DIV1, ({1'b0, rem_q} < {dsh_q, 1'b0}), "divider remainder out of range")
  `MRM_ASSERT_NOW(a_sqrt_bound, state_q == ST_SQRT, (srem_q <= {1'b0, root_q, 1'b0}), "root remainder out of range")

endmodule

// ----- sim/tb_moving_rms_meter.sv -----
// testbench of the moving rms meter: streams samples in, checks every rms result
// against its own running-window predictor; needs mrm_pkg and moving_rms_meter
`timescale 1ns / 1ps

module tb_moving_rms_meter;

  import mrm_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int REG_SPARE = 1;
  localparam logic [ADDR_W-1:0] FS_ADDR    = ADDR_W'(4 * REG_FULL_SCALE);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * REG_SPARE);
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [Q_W-1:0]  q8;
    logic [MV_W-1:0] mv;
    logic            full;
  } rms_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;  // rms_q8[15:0], rms_mv[28:16], zero[31:29]
  logic                m_axis_tuser;  // window_full
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state
  logic [SAMPLE_W-1:0] ring_copy [WIN];
  int unsigned         sumsq_copy;
  int unsigned         fill_copy;
  int unsigned         slot_copy;
  logic [FS_W-1:0]     fs_copy;

  rms_result_t rms_expected [$];
  rms_result_t rms_head;
  int          errors = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          fs_settings = 1;
  bit          idle_on = 1'b1;
  int          hold_left = 0;
  int          rx_gap = 0;

  moving_rms_meter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [Q_W-1:0] root_floor(input logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem = radicand;
    root = '0;
    b = 64'h1 << 32;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[Q_W-1:0];
  endfunction

  function automatic rms_result_t predict_rms(input logic [SAMPLE_W-1:0] s);
    rms_result_t r;
    int unsigned old;
    int unsigned mean_sq;
    logic [63:0] root;
    old = ring_copy[slot_copy];
    sumsq_copy = sumsq_copy - old * old + s * s;
    ring_copy[slot_copy] = s;
    slot_copy = (slot_copy + 1 == WIN) ? 0 : slot_copy + 1;
    if (fill_copy < WIN) fill_copy++;
    mean_sq = sumsq_copy / fill_copy;
    root = root_floor(64'(mean_sq) << 16);
    if (root > Q8_FULL) root = Q8_FULL;
    r.q8 = root[Q_W-1:0];
    r.mv = MV_W'((root * fs_copy) / Q8_FULL);
    r.full = (fill_copy == WIN);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rms_expected.size() == 0) begin
        errors++;
        $display("%0t: result with no sample pending, expected none actual %h",
                 $time, m_axis_tdata);
      end else begin
        rms_head = rms_expected.pop_front();
        if (m_axis_tdata[15:0] !== rms_head.q8)
          report_mismatch("rms_q8", rms_head.q8, m_axis_tdata[15:0]);
        if (m_axis_tdata[28:16] !== rms_head.mv)
          report_mismatch("rms_mv", rms_head.mv, m_axis_tdata[28:16]);
        if (m_axis_tuser !== rms_head.full)
          report_mismatch("window_full", rms_head.full, m_axis_tuser);
        results_checked++;
      end
    end
  end

  // result receiver with random gaps and long hold-offs
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) rx_gap = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    rms_expected.push_back(predict_rms(s));
    samples_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (rms_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == FS_ADDR) begin
      fs_copy = data[FS_W-1:0];
      fs_settings++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_full_scale_readback();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FS_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[FS_W-1:0] !== fs_copy) report_mismatch("full_scale readback", fs_copy,
                                                      prdata[FS_W-1:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_full_scale(input logic [31:0] data);
    wait_idle();
    apb_write(FS_ADDR, data);
    check_full_scale_readback();
  endtask

  // window fill from reset, then wrap of the ring
  task automatic test_startup_fill();
    logic [SAMPLE_W-1:0] seq [12] = '{8'd255, 8'd255, 8'd0, 8'd128, 8'd1, 8'd254,
                                      8'd0, 8'd255, 8'd17, 8'd200, 8'd255, 8'd0};
    check_full_scale_readback();
    foreach (seq[k]) send_sample(seq[k]);
  endtask

  // zero, minimum, top of range and all-ones full scale
  task automatic test_full_scale_extremes();
    logic [FS_W-1:0] fs_list [4] = '{13'd0, 13'd1, 13'd5000, 13'd8191};
    foreach (fs_list[k]) begin
      set_full_scale({19'd0, fs_list[k]});
      send_sample(8'd255);
      send_sample(SAMPLE_W'($urandom));
    end
  endtask

  // spare address ignored, upper data bits dropped
  task automatic test_register_decode();
    wait_idle();
    apb_write(SPARE_ADDR, $urandom);
    check_full_scale_readback();
    send_sample(8'd255);
    set_full_scale(32'hFFFF_E000 | 32'd2980);
    send_sample(8'd128);
  endtask

  // output held off long enough to back up the input
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_left = 400;
    repeat (16) send_sample(SAMPLE_W'($urandom));
    idle_on = 1'b1;
  endtask

  task automatic test_random_stream(input int phases, input int per_phase);
    int level;
    int pick;
    int v;
    level = 128;
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0: set_full_scale($urandom_range(1, 5000));
        1: set_full_scale(32'd5000);
        2: set_full_scale(32'd1);
        default: set_full_scale($urandom);
      endcase
      idle_on = (p % 3 != 1);
      for (int k = 0; k < per_phase; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          v = $urandom_range(0, 1) ? 255 : 0;
        end else if (pick < 6) begin
          v = $urandom_range(0, 255);
        end else begin
          if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 255);
          v = level + $urandom_range(0, 16) - 8;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        send_sample(SAMPLE_W'(v));
      end
    end
  endtask

  initial begin
    for (int k = 0; k < WIN; k++) ring_copy[k] = '0;
    sumsq_copy = 0;
    fill_copy = 0;
    slot_copy = 0;
    fs_copy = FS_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_startup_fill();
    test_full_scale_extremes();
    test_register_decode();
    test_backpressure();
    test_random_stream(6, 300);
    wait_idle();

    $display("run covered %0d samples and %0d checked results", samples_sent,
             results_checked);
    $display("over %0d full-scale settings, window fill, wrap and long output stall",
             fs_settings);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
